FILE: rtl/clrng_pkg.sv
package clrng_pkg;

  localparam int VAL_W  = 31;
  localparam int MUL_W  = 16;
  localparam int FOLD_C_W = 8;
  localparam int PROD_W = VAL_W + MUL_W;
  localparam int FOLD_W = VAL_W + 1;

  localparam logic [VAL_W-1:0] MOD_A        = 31'd2147483563;
  localparam logic [VAL_W-1:0] MOD_B        = 31'd2147483399;
  localparam logic [VAL_W-1:0] WRAP_ADD     = 31'd2147483562;
  localparam logic [VAL_W-1:0] SECOND_RESET = 31'd123456789;

  localparam logic [MUL_W-1:0] MUL_A = 16'd40014;
  localparam logic [MUL_W-1:0] MUL_B = 16'd40692;

  // 2^31 minus each modulus, used to fold the high product bits back in
  localparam logic [FOLD_C_W-1:0] FOLD_A = 8'd85;
  localparam logic [FOLD_C_W-1:0] FOLD_B = 8'd249;

  localparam int WARMUP         = 8;
  localparam int TABLE_SIZE_DEF = 32;

  typedef struct packed {
    logic load_seed;
    logic mul;
    logic fold;
    logic fill_sub;
    logic draw_sub;
    logic finish;
  } rng_cmd_t;

  typedef struct packed {
    logic fill_done;
    logic out_busy;
  } rng_sts_t;

endpackage

FILE: rtl/clrng_if.sv
interface clrng_in_if;
  import clrng_pkg::*;

  logic             valid;
  logic             ready;
  logic             command;
  logic [VAL_W-1:0] seed_magnitude;

  modport source (output valid, output command, output seed_magnitude, input ready);
  modport sink   (input valid, input command, input seed_magnitude, output ready);
endinterface

interface clrng_out_if;
  import clrng_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

FILE: rtl/clrng_ctrl.sv
module clrng_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_command_i,
  output logic                in_ready_o,
  input  clrng_pkg::rng_sts_t sts_i,
  output clrng_pkg::rng_cmd_t cmd_o
);
  import clrng_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FMUL,
    ST_FFOLD,
    ST_FSUB,
    ST_MUL,
    ST_FOLD,
    ST_SUB,
    ST_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_command_i) begin
            cmd_o.load_seed = 1'b1;
            state_d         = ST_FMUL;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_FMUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FFOLD;
      end
      ST_FFOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = ST_FSUB;
      end
      ST_FSUB: begin
        cmd_o.fill_sub = 1'b1;
        state_d        = sts_i.fill_done ? ST_MUL : ST_FMUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = ST_SUB;
      end
      ST_SUB: begin
        cmd_o.draw_sub = 1'b1;
        state_d        = ST_FIN;
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/clrng_dp.sv
module clrng_dp #(
  parameter int TABLE_SIZE = clrng_pkg::TABLE_SIZE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [clrng_pkg::VAL_W-1:0]  in_seed_i,
  input  clrng_pkg::rng_cmd_t          cmd_i,
  output clrng_pkg::rng_sts_t          sts_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [clrng_pkg::VAL_W-1:0]  out_value_o
);
  import clrng_pkg::*;

  localparam int    IDX_W    = $clog2(TABLE_SIZE);
  localparam int    CNT_W    = $clog2(TABLE_SIZE + WARMUP);
  localparam longint NDIV    = 64'd1 + 64'd2147483562 / TABLE_SIZE;
  localparam longint RECIP   = (64'd1 << VAL_W) / NDIV;
  localparam int    R_W      = $clog2(TABLE_SIZE + 1);
  localparam int    Q_W      = R_W + 1;
  localparam int    QP_W     = VAL_W + R_W;
  localparam int    HC_W     = MUL_W + FOLD_C_W;

  localparam logic [R_W-1:0]   RECIP_V  = R_W'(RECIP);
  localparam logic [QP_W-1:0]  NDIV_V   = QP_W'(NDIV);
  localparam logic [Q_W-1:0]   SLOT_MAX = Q_W'(TABLE_SIZE - 1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(TABLE_SIZE + WARMUP - 1);
  localparam logic [CNT_W-1:0] CNT_TAB  = CNT_W'(TABLE_SIZE);

  logic [VAL_W-1:0]  gen_a_q, gen_b_q, last_q, out_q;
  logic              out_valid_q;
  logic [PROD_W-1:0] prod_a_q, prod_b_q;
  logic [FOLD_W-1:0] fold_a_q, fold_b_q;
  logic [R_W-1:0]    q0_q;
  logic [IDX_W-1:0]  slot_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [VAL_W-1:0]      mem_q [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vld_q;
  logic [VAL_W-1:0]      rd_q;
  logic                  rd_vld_q;

  logic [VAL_W-1:0]  seed_v;
  logic [HC_W-1:0]   hc_a, hc_b;
  logic [FOLD_W-1:0] fold_a_d, fold_b_d;
  logic [VAL_W-1:0]  red_a, red_b;
  logic [QP_W-1:0]   q0_prod, qn, rem;
  logic [Q_W-1:0]    q_fix;
  logic [IDX_W-1:0]  slot_d;
  logic [VAL_W-1:0]  entry;
  logic signed [VAL_W+1:0] diff;
  logic [VAL_W-1:0]  result;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [VAL_W-1:0]  wdata;

  assign seed_v = (in_seed_i == '0) ? VAL_W'(1) : in_seed_i;

  // fold high part of the product: 2^31 is congruent to the fold constant
  assign hc_a     = prod_a_q[PROD_W-1:VAL_W] * FOLD_A;
  assign hc_b     = prod_b_q[PROD_W-1:VAL_W] * FOLD_B;
  assign fold_a_d = {1'b0, prod_a_q[VAL_W-1:0]} + FOLD_W'(hc_a);
  assign fold_b_d = {1'b0, prod_b_q[VAL_W-1:0]} + FOLD_W'(hc_b);

  assign red_a = (fold_a_q >= {1'b0, MOD_A}) ? VAL_W'(fold_a_q - {1'b0, MOD_A})
                                              : fold_a_q[VAL_W-1:0];
  assign red_b = (fold_b_q >= {1'b0, MOD_B}) ? VAL_W'(fold_b_q - {1'b0, MOD_B})
                                              : fold_b_q[VAL_W-1:0];

  // slot = last / NDIV via reciprocal estimate and one correction
  assign q0_prod = last_q * RECIP_V;
  assign qn      = q0_q * NDIV_V;
  assign rem     = QP_W'(last_q) - qn;
  assign q_fix   = (rem >= NDIV_V) ? Q_W'(q0_q) + Q_W'(1) : Q_W'(q0_q);
  assign slot_d  = (q_fix > SLOT_MAX) ? SLOT_MAX[IDX_W-1:0] : q_fix[IDX_W-1:0];

  assign entry  = rd_vld_q ? rd_q : '0;
  assign diff   = $signed({2'b00, entry}) - $signed({2'b00, gen_b_q});
  assign result = (diff < 1) ? VAL_W'(diff + $signed({2'b00, WRAP_ADD}))
                             : diff[VAL_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = slot_q;
    wdata = gen_a_q;
    if (cmd_i.fill_sub && (cnt_q < CNT_TAB)) begin
      we    = 1'b1;
      waddr = cnt_q[IDX_W-1:0];
      wdata = red_a;
    end else if (cmd_i.finish) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.draw_sub) begin
      rd_q <= mem_q[slot_q];
    end
    if (cmd_i.mul) begin
      prod_a_q <= gen_a_q * MUL_A;
      prod_b_q <= gen_b_q * MUL_B;
      q0_q     <= q0_prod[QP_W-1:VAL_W];
    end
    if (cmd_i.fold) begin
      fold_a_q <= fold_a_d;
      fold_b_q <= fold_b_d;
      slot_q   <= slot_d;
    end
    if (cmd_i.finish) begin
      out_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_a_q     <= VAL_W'(1);
      gen_b_q     <= SECOND_RESET;
      last_q      <= '0;
      cnt_q       <= '0;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (cmd_i.draw_sub) begin
        rd_vld_q <= vld_q[slot_q];
      end
      if (cmd_i.load_seed) begin
        gen_a_q <= seed_v;
        gen_b_q <= seed_v;
        cnt_q   <= CNT_LOAD;
      end
      if (cmd_i.fill_sub) begin
        gen_a_q <= red_a;
        if (cnt_q == '0) begin
          last_q <= red_a;
        end else begin
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
      if (cmd_i.draw_sub) begin
        gen_a_q <= red_a;
        gen_b_q <= red_b;
      end
      if (cmd_i.finish) begin
        last_q      <= result;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.fill_done = (cnt_q == '0);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_value_o     = out_q;

endmodule

FILE: rtl/combined_lcg_shuffle_rng_top.sv
// draw: a beat steps through multiply, fold, subtract and finish; the next is taken in idle
// reseed: adds TABLE_SIZE + 8 iterations of one modular step, the last TABLE_SIZE fill the table
// each step is a 31x16 multiply, a fold of the high bits and a conditional subtract
// a pending result waits in the output register; the next beat is taken meanwhile
// reset: generators 1 and 123456789, last output 0, table reads zero through valid bits
module combined_lcg_shuffle_rng_top #(
  parameter int TABLE_SIZE = clrng_pkg::TABLE_SIZE_DEF
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  clrng_in_if.sink    in_i,
  clrng_out_if.source out_o
);
  import clrng_pkg::*;

  rng_cmd_t cmd;
  rng_sts_t sts;

  clrng_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_command_i (in_i.command),
    .in_ready_o   (in_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  clrng_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_seed_i   (in_i.seed_magnitude),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_value_o (out_o.random_value)
  );

  a_out_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.random_value != '0)
    else $error("result beat carries zero");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken again before the draw finished");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_o.valid)
    else $error("finished draw not presented");

endmodule
